// ===== rtl/core/skh_pkg.sv =====
// Shared types, constants and a helper function of the string key hash table.
package skh_pkg;

    // Field widths of one transfer
    localparam int KEY_W = 64;
    localparam int LEN_W = 4;
    localparam int VAL_W = 32;

    // Default table size and the longest key that is kept
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int KEY_MAX_BYTES     = 8;

    // Load bound: a put is refused while (count + 1) * LOAD_DEN >= size * LOAD_NUM
    localparam int LOAD_NUM = 7;
    localparam int LOAD_DEN = 10;

    // 64-bit FNV-1a rounds from a start value that is not the standard FNV offset basis; the prime is 2^40 + 0x1B3
    localparam logic [63:0] FNV_BASIS       = 64'd1469598103934665603;
    localparam int          FNV_PRIME_SHIFT = 40;
    localparam logic [63:0] FNV_PRIME_LOW   = 64'h1B3;

    // Operation codes
    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    // Status codes
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [KEY_W-1:0] key_bytes;
        logic [LEN_W-1:0] key_length;
        logic [VAL_W-1:0] put_value;
    } in_item_t;

    typedef struct packed {
        logic             status;
        logic             key_found;
        logic [VAL_W-1:0] read_value;
    } out_item_t;

    // One table slot as held in the memory
    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] key_length;
        logic [VAL_W-1:0] value;
    } slot_entry_t;

    // One FNV-1a round: xor in the byte, multiply by the prime (mod 2^64)
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << FNV_PRIME_SHIFT) + 64'(x * FNV_PRIME_LOW);
    endfunction

endpackage

// ===== rtl/core/string_key_hash_table.sv =====
// Top level of the string key hash table: probe sequencer, slot memory and result register.
// A put or get of a key of up to eight bytes against an open-addressing table
// with linear probing. One item is worked on at a time: s_ready is high only
// while the block waits for an item. An item is accepted, hashed byte-serially
// with FNV-1a, its slot is handed over, the hash is reduced to a slot index when
// TABLE_ENTRIES is not a power of two, slots are probed in turn, one a cycle (the
// slot memory delivers one entry a cycle), and the result register is loaded. A
// put refused by the load bound skips hashing and probing and goes straight to
// the result register. The result register lets a new item in while the last
// result waits. After reset the block clears the slot memory, one slot a cycle,
// before it takes its first item.
module string_key_hash_table
    import skh_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int IDX_W      = $clog2(TABLE_ENTRIES);
    localparam int CNT_W      = $clog2(TABLE_ENTRIES + 1);
    localparam int LOAD_LIMIT = (TABLE_ENTRIES * LOAD_NUM + LOAD_DEN - 1) / LOAD_DEN - 1;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_PROBE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic             op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    out_item_t        result_reg, result_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_item_reg, m_item_next;

    logic [LEN_W-1:0] len_clamp;
    logic [KEY_W-1:0] norm_key;
    logic [LEN_W-1:0] norm_len;
    logic             key_alive;
    logic             table_full;
    logic [IDX_W-1:0] idx_wrap;
    logic             slot_hit;

    logic             hash_start;
    logic             hash_done;
    logic [IDX_W-1:0] hash_slot;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    slot_entry_t      ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    slot_entry_t      ram_rdata;

    // Key normalization: clamp the length, stop at the first zero byte
    always_comb begin
        len_clamp = (s_item.key_length > LEN_W'(KEY_MAX_BYTES)) ?
                    LEN_W'(KEY_MAX_BYTES) : s_item.key_length;
        key_alive = 1'b1;
        norm_key  = '0;
        norm_len  = '0;
        for (int i = 0; i < 8; i++) begin
            if (key_alive && (LEN_W'(i) < len_clamp) && (s_item.key_bytes[8*i +: 8] != 8'd0)) begin
                norm_key[8*i +: 8] = s_item.key_bytes[8*i +: 8];
                norm_len           = norm_len + LEN_W'(1);
            end else begin
                key_alive = 1'b0;
            end
        end
    end

    assign table_full = count_reg >= CNT_W'(LOAD_LIMIT);
    assign idx_wrap   = (idx_reg == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : idx_reg + IDX_W'(1);
    assign slot_hit   = ram_rdata.used && (ram_rdata.key == key_reg)
                        && (ram_rdata.key_length == len_reg);

    skh_hash #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (norm_key),
        .key_len (norm_len),
        .done    (hash_done),
        .slot    (hash_slot)
    );

    skh_ram #(
        .WIDTH($bits(slot_entry_t)),
        .DEPTH(TABLE_ENTRIES)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Probe sequencer
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        len_next     = len_reg;
        value_next   = value_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        clr_idx_next = clr_idx_reg;
        count_next   = count_reg;
        result_next  = result_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg && !m_ready;
        hash_start   = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = '0;
        ram_raddr    = idx_reg;
        case (state_reg)
            S_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_item.operation;
                    key_next   = norm_key;
                    len_next   = norm_len;
                    value_next = s_item.put_value;
                    if ((s_item.operation == OP_PUT) && table_full) begin
                        result_next.status     = STATUS_FULL;
                        result_next.key_found  = 1'b0;
                        result_next.read_value = '0;
                        state_next             = S_DONE;
                    end else begin
                        hash_start = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH: begin
                // first read goes out as the home slot arrives
                ram_raddr = hash_slot;
                if (hash_done) begin
                    idx_next   = hash_slot;
                    step_next  = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                // next slot is read ahead; used only when the probe goes on
                ram_raddr                    = idx_wrap;
                ram_wdata.used               = 1'b1;
                ram_wdata.key                = key_reg;
                ram_wdata.key_length         = len_reg;
                ram_wdata.value              = value_reg;
                result_next.status           = STATUS_DONE;
                result_next.key_found        = 1'b0;
                result_next.read_value       = '0;
                if (!ram_rdata.used) begin
                    if (op_reg == OP_PUT) begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = S_DONE;
                end else if (slot_hit) begin
                    if (op_reg == OP_PUT) begin
                        ram_we = 1'b1;
                    end else begin
                        result_next.read_value = ram_rdata.value;
                    end
                    result_next.key_found = 1'b1;
                    state_next            = S_DONE;
                end else if (step_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                    state_next = S_DONE;
                end else begin
                    idx_next  = idx_wrap;
                    step_next = step_reg + IDX_W'(1);
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_item_next  = result_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Item and result registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        len_reg    <= len_next;
        value_reg  <= value_next;
        idx_reg    <= idx_next;
        step_reg   <= step_next;
        result_reg <= result_next;
        m_item_reg <= m_item_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ===== rtl/core/skh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module skh_ram
    import skh_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/skh_hash.sv =====
// Byte-serial FNV-1a hash of a key, reduced to a slot index of the table.
module skh_hash
    import skh_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [KEY_W-1:0]                 key,
    input  logic [LEN_W-1:0]                 key_len,
    output logic                             done,
    output logic [$clog2(TABLE_ENTRIES)-1:0] slot
);

    localparam int  IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int  REM_W  = IDX_W + 1;
    localparam bit  IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

    typedef enum logic [2:0] {
        H_IDLE  = 3'b001,
        H_BYTES = 3'b010,
        H_MOD   = 3'b100
    } hash_state_t;

    hash_state_t      state_reg, state_next;
    logic [63:0]      h_reg, h_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [IDX_W-1:0] rem_reg, rem_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             done_reg, done_next;

    logic [63:0]      h_step;
    logic [63:0]      h_cur;
    logic             last_byte;
    logic [REM_W-1:0] mod_acc;
    logic [IDX_W-1:0] mod_rem;

    // One hash round on the current byte
    assign h_step    = fnv_step(h_reg, key_reg[{cnt_reg[2:0], 3'b000} +: 8]);
    assign h_cur     = ({1'b0, cnt_reg} < {1'b0, len_reg}) ? h_step : h_reg;
    assign last_byte = ({1'b0, cnt_reg} + 5'd1) >= {1'b0, len_reg};

    // Remainder: eight bits of the hash a cycle, most significant first
    always_comb begin
        mod_acc = '0;
        mod_rem = rem_reg;
        for (int b = 7; b >= 0; b--) begin
            mod_acc = {mod_rem, h_reg[56 + b]};
            if (mod_acc >= REM_W'(TABLE_ENTRIES)) begin
                mod_acc = mod_acc - REM_W'(TABLE_ENTRIES);
            end
            mod_rem = mod_acc[IDX_W-1:0];
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        h_next     = h_reg;
        key_next   = key_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        slot_next  = slot_reg;
        done_next  = 1'b0;
        case (state_reg)
            H_IDLE: begin
                if (start) begin
                    h_next     = FNV_BASIS;
                    key_next   = key;
                    len_next   = key_len;
                    cnt_next   = '0;
                    state_next = H_BYTES;
                end
            end
            H_BYTES: begin
                h_next   = h_cur;
                cnt_next = cnt_reg + 4'd1;
                if (last_byte) begin
                    if (IS_POW2) begin
                        slot_next  = h_cur[IDX_W-1:0];
                        done_next  = 1'b1;
                        state_next = H_IDLE;
                    end else begin
                        cnt_next   = '0;
                        rem_next   = '0;
                        state_next = H_MOD;
                    end
                end
            end
            H_MOD: begin
                h_next   = h_reg << 8;
                rem_next = mod_rem;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd7) begin
                    slot_next  = mod_rem;
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
            end
            default: begin
                state_next = H_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        h_reg    <= h_next;
        key_reg  <= key_next;
        len_reg  <= len_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        slot_reg <= slot_next;
    end

    assign done = done_reg;
    assign slot = slot_reg;

endmodule
